FILE: rtl/ems_pmr_pkg.sv
`default_nettype none
package ems_pmr_pkg;

  localparam int WINDOW_PAGES_DEF = 12;
  localparam int EEPROM_WORDS_DEF = 64;

  localparam int MAP_W = 10;
  localparam int EE_W  = 16;

  // bus command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register addresses
  localparam logic [15:0] ADDR_BOARD_ID  = 16'h0259;
  localparam logic [15:0] ADDR_DETECT    = 16'h025F;
  localparam logic [15:0] ADDR_PAGE_MASK = 16'h125F;
  localparam logic [15:0] ADDR_LATCH_LO  = 16'hC25C;
  localparam logic [15:0] ADDR_LATCH_HI  = 16'hC25D;
  localparam logic [15:0] ADDR_EE_CMD    = 16'hC25E;

  localparam logic [7:0] BOARD_ID       = 8'h18;
  localparam logic [7:0] READ_UNMATCHED = 8'hFF;

  // eeprom command codes, bits 7:6 of the command byte
  localparam logic [1:0] EE_CMD_LOAD  = 2'd2;
  localparam logic [1:0] EE_CMD_STORE = 2'd3;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_MAP   = 2'd1,
    ACT_UNMAP = 2'd2
  } map_action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic        command;
    logic [15:0] io_address;
    logic [7:0]  write_byte;
  } request_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    map_action_t map_action;
    logic [3:0]  window_index;
    logic [8:0]  board_page;
  } result_t;

  typedef struct packed {
    logic             win_we;
    logic [MAP_W-1:0] win_wdata;
    logic             detect_we;
    logic             mask_we;
    logic             latch_we;
    logic [EE_W-1:0]  latch_value;
    logic             ee_we;
  } update_t;

  // window index from a page register address, meaningful for nibbles 6 to 8
  function automatic logic [3:0] window_index(input logic [15:0] addr);
    logic [3:0] nib_off;
    nib_off = addr[3:0] - 4'd6;
    return {nib_off[1:0], addr[15:14]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ems_page_map_registers.sv
`default_nettype none
// expanded-memory board register file. each bus access (read or write of one
// byte at a 16-bit i/o address) is one transfer on request, taken at a clock
// edge with start high and busy low. the page map and the eeprom words sit in
// two synchronous memories: the transfer edge launches the reads, the next
// cycle (busy high) decodes the access, updates registers and writes back,
// and the cycle after that shows the result on result with done high for
// exactly one cycle. the receiver cannot stall, so a result is never held.
// a new transfer can be taken in the same cycle as done, but not while busy;
// the memory read ahead of the read-modify-write is why transfers cannot
// overlap. memories clear through per-entry valid bits, so there is
// no clearing pass after reset.
module ems_page_map_registers #(
  parameter int WINDOW_PAGES = ems_pmr_pkg::WINDOW_PAGES_DEF,
  parameter int EEPROM_WORDS = ems_pmr_pkg::EEPROM_WORDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ems_pmr_pkg::request_t request,
  output logic                       done,
  output ems_pmr_pkg::result_t       result
);

  localparam int WIN_AW = (WINDOW_PAGES > 1) ? $clog2(WINDOW_PAGES) : 1;
  localparam int EE_AW  = (EEPROM_WORDS > 1) ? $clog2(EEPROM_WORDS) : 1;

  ems_pmr_pkg::state_t   state, state_next;
  ems_pmr_pkg::request_t req;
  ems_pmr_pkg::result_t  rsp;
  ems_pmr_pkg::update_t  upd;

  logic                          accept;
  logic                          exec;
  logic [3:0]                    in_idx;
  logic [5:0]                    in_word;
  logic [WIN_AW-1:0]             win_addr_in;
  logic [EE_AW-1:0]              ee_addr_in;
  logic [WIN_AW-1:0]             win_addr;
  logic [EE_AW-1:0]              ee_addr;
  logic [ems_pmr_pkg::MAP_W-1:0] win_rd;
  logic [ems_pmr_pkg::EE_W-1:0]  ee_rd;
  logic [7:0]                    detect_reg;
  logic [7:0]                    window_enable_mask;
  logic [ems_pmr_pkg::EE_W-1:0]  eeprom_latch;

  // handshake and sequencing
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    exec       = 1'b0;
    case (state)
      ems_pmr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ems_pmr_pkg::ST_EXEC;
        end
      end
      ems_pmr_pkg::ST_EXEC: begin
        busy       = 1'b1;
        exec       = 1'b1;
        state_next = ems_pmr_pkg::ST_IDLE;
      end
      default: state_next = ems_pmr_pkg::ST_IDLE;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ems_pmr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory addresses taken straight from the incoming transfer;
  // out-of-range indices park at entry zero and their data is ignored
  always_comb begin
    in_idx      = ems_pmr_pkg::window_index(request.io_address);
    in_word     = request.write_byte[5:0];
    win_addr_in = (32'(in_idx) < WINDOW_PAGES) ? in_idx[WIN_AW-1:0] : '0;
    ee_addr_in  = (32'(in_word) < EEPROM_WORDS) ? in_word[EE_AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= request;
      win_addr <= win_addr_in;
      ee_addr  <= ee_addr_in;
    end
  end

  ems_pmr_mem #(
    .DEPTH (WINDOW_PAGES),
    .WIDTH (ems_pmr_pkg::MAP_W),
    .AW    (WIN_AW)
  ) u_win_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (win_addr_in),
    .rd_data (win_rd),
    .we      (exec && upd.win_we),
    .wr_addr (win_addr),
    .wr_data (upd.win_wdata)
  );

  ems_pmr_mem #(
    .DEPTH (EEPROM_WORDS),
    .WIDTH (ems_pmr_pkg::EE_W),
    .AW    (EE_AW)
  ) u_ee_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ee_addr_in),
    .rd_data (ee_rd),
    .we      (exec && upd.ee_we),
    .wr_addr (ee_addr),
    .wr_data (eeprom_latch)
  );

  // decode of the held access against the memory read data
  ems_pmr_exec #(
    .WINDOW_PAGES (WINDOW_PAGES),
    .EEPROM_WORDS (EEPROM_WORDS)
  ) u_exec (
    .req    (req),
    .win_rd (win_rd),
    .ee_rd  (ee_rd),
    .detect (detect_reg),
    .mask   (window_enable_mask),
    .latch  (eeprom_latch),
    .rsp    (rsp),
    .upd    (upd)
  );

  // small registers, updated in the execute cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_reg         <= '0;
      window_enable_mask <= '0;
      eeprom_latch       <= '0;
    end else if (exec) begin
      if (upd.detect_we) begin
        detect_reg <= req.write_byte;
      end
      if (upd.mask_we) begin
        window_enable_mask <= req.write_byte;
      end
      if (upd.latch_we) begin
        eeprom_latch <= upd.latch_value;
      end
    end
  end

  // output register: result shown for one cycle after execute
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      result <= rsp;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ems_pmr_mem.sv
`default_nettype none
module ems_pmr_mem #(
  parameter int DEPTH = 12,
  parameter int WIDTH = 10,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

FILE: rtl/ems_pmr_exec.sv
`default_nettype none
module ems_pmr_exec #(
  parameter int WINDOW_PAGES = ems_pmr_pkg::WINDOW_PAGES_DEF,
  parameter int EEPROM_WORDS = ems_pmr_pkg::EEPROM_WORDS_DEF
) (
  input  wire ems_pmr_pkg::request_t               req,
  input  wire logic [ems_pmr_pkg::MAP_W-1:0]       win_rd,
  input  wire logic [ems_pmr_pkg::EE_W-1:0]        ee_rd,
  input  wire logic [7:0]                          detect,
  input  wire logic [7:0]                          mask,
  input  wire logic [ems_pmr_pkg::EE_W-1:0]        latch,
  output ems_pmr_pkg::result_t                     rsp,
  output ems_pmr_pkg::update_t                     upd
);

  logic [3:0] nib;
  logic [1:0] hi;
  logic [3:0] idx;
  logic [5:0] word;
  logic       page_nib;
  logic       win_ok;
  logic       ee_ok;
  logic [7:0] wb;

  always_comb begin
    nib      = req.io_address[3:0];
    hi       = req.io_address[13:12];
    idx      = ems_pmr_pkg::window_index(req.io_address);
    wb       = req.write_byte;
    word     = wb[5:0];
    page_nib = nib inside {[4'd6:4'd8]};
    win_ok   = 32'(idx) < WINDOW_PAGES;
    ee_ok    = 32'(word) < EEPROM_WORDS;
    rsp      = '0;
    upd      = '0;

    if (req.command == ems_pmr_pkg::CMD_WRITE) begin
      if (nib <= 4'd8) begin
        if (page_nib && win_ok) begin
          upd.win_we    = 1'b1;
          upd.win_wdata = {hi, wb};
          // windows 0 to 7 are gated by the page mask
          if (idx[3] || mask[idx[2:0]]) begin
            rsp.window_index = idx;
            if (wb[7]) begin
              rsp.map_action = ems_pmr_pkg::ACT_MAP;
              rsp.board_page = {hi, wb[6:0]};
            end else begin
              rsp.map_action = ems_pmr_pkg::ACT_UNMAP;
            end
          end
        end
      end else begin
        case (req.io_address)
          ems_pmr_pkg::ADDR_DETECT: begin
            upd.detect_we = 1'b1;
          end
          ems_pmr_pkg::ADDR_PAGE_MASK: begin
            upd.mask_we = 1'b1;
          end
          ems_pmr_pkg::ADDR_LATCH_LO: begin
            upd.latch_we    = 1'b1;
            upd.latch_value = {latch[15:8], wb};
          end
          ems_pmr_pkg::ADDR_LATCH_HI: begin
            upd.latch_we    = 1'b1;
            upd.latch_value = {wb, latch[7:0]};
          end
          ems_pmr_pkg::ADDR_EE_CMD: begin
            case (wb[7:6])
              ems_pmr_pkg::EE_CMD_LOAD: begin
                upd.latch_we    = 1'b1;
                upd.latch_value = ee_ok ? ee_rd : '0;
              end
              ems_pmr_pkg::EE_CMD_STORE: begin
                upd.ee_we = ee_ok;
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end else begin
      if (hi == 2'd0 && page_nib && win_ok) begin
        rsp.read_byte = win_rd[7:0];
      end else begin
        case (req.io_address)
          ems_pmr_pkg::ADDR_BOARD_ID: rsp.read_byte = ems_pmr_pkg::BOARD_ID;
          ems_pmr_pkg::ADDR_DETECT:
            rsp.read_byte = {detect[7:5], 2'b11, detect[2:0] + 3'd3};
          ems_pmr_pkg::ADDR_LATCH_LO: rsp.read_byte = latch[7:0];
          ems_pmr_pkg::ADDR_LATCH_HI: rsp.read_byte = latch[15:8];
          default: rsp.read_byte = ems_pmr_pkg::READ_UNMATCHED;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ems_pmr_checker.sv
`default_nettype none
module ems_pmr_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire ems_pmr_pkg::request_t request,
  input wire logic                  done,
  input wire ems_pmr_pkg::result_t  result
);

  // a taken transfer is worked on in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer taken without going busy");

  // every busy cycle ends in exactly one result strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy cycle not followed by a result");

  // a write returns no read data
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == ems_pmr_pkg::CMD_WRITE)
      |=> ##1 (done && result.read_byte == 8'd0))
    else $error("write result carries read data");

  // no event fields without an event
  a_quiet_event: assert property (@(posedge clk) disable iff (rst)
    (done && result.map_action == ems_pmr_pkg::ACT_NONE)
      |-> (result.window_index == 4'd0 && result.board_page == 9'd0))
    else $error("event fields set without an event");

  // only a map names a board page
  a_unmap_page: assert property (@(posedge clk) disable iff (rst)
    (done && result.map_action == ems_pmr_pkg::ACT_UNMAP)
      |-> (result.board_page == 9'd0 && result.read_byte == 8'd0))
    else $error("unmap carries page or read data");

endmodule

bind ems_page_map_registers ems_pmr_checker u_ems_pmr_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
`default_nettype wire
